@@ rtl/fifo_with_move_to_front_defines.svh @@
// Assertion macros for the move-to-front queue.
// No dependencies; included by the top level.
`ifndef FIFO_WITH_MOVE_TO_FRONT_DEFINES_SVH
`define FIFO_WITH_MOVE_TO_FRONT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check that a condition in one cycle implies another in the same cycle.
`define FWMTF_ASSERT_SAME(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);
// Check that a condition in one cycle implies another in the next cycle.
`define FWMTF_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`else
`define FWMTF_ASSERT_SAME(label, clk, rst_n, cond, prop, msg)
`define FWMTF_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif

`endif

@@ rtl/fwmtf_pkg.sv @@
// Shared types and constants of the move-to-front queue.
// No dependencies; used by the channel interfaces and the top level.
package fwmtf_pkg;

	localparam int WORD_W = 32;
	localparam int OCC_W  = 5;
	localparam int REQ_W  = 2;
	localparam int ST_W   = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH = 2'd0,
		REQ_POP  = 2'd1,
		REQ_PEEK = 2'd2,
		REQ_MTF  = 2'd3
	} req_kind_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

endpackage

@@ rtl/fwmtf_if.sv @@
// Valid/ready channel interfaces for requests and responses.
// Depends on fwmtf_pkg for the field widths.
interface fwmtf_req_if import fwmtf_pkg::*;;
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [WORD_W-1:0] value;

	modport source (output valid, req_type, value, input ready);
	modport sink (input valid, req_type, value, output ready);
endinterface

interface fwmtf_rsp_if import fwmtf_pkg::*;;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] out_value;
	logic [ST_W-1:0]   status;
	logic [OCC_W-1:0]  occupancy;

	modport source (output valid, out_value, status, occupancy, input ready);
	modport sink (input valid, out_value, status, occupancy, output ready);
endinterface

@@ rtl/fifo_with_move_to_front.sv @@
// Bounded FIFO with move-to-front, one request at a time (ready only while idle).
// Push appends at the tail; pop and peek read the head word via the read port;
// move-to-front scans from the head, then on a match behind the head shifts the
// entries ahead of it back one slot and writes the key at the head (no match: NOTFOUND).
// A stalled response holds the sequencer until the response register frees.
// Reset (arst_n low) empties the queue at once; stored words are not cleared.
`include "fifo_with_move_to_front_defines.svh"

module fifo_with_move_to_front import fwmtf_pkg::*; #(
	parameter int DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	fwmtf_req_if.sink  req,
	fwmtf_rsp_if.source rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_SCAN,
		S_SHIFT,
		S_PLACE,
		S_RESPOND
	} state_t;

	// Storage: one write port, one registered read port.
	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;

	state_t            state_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     idx_q;   // scan offset, then shift position
	logic [WORD_W-1:0] key_q;
	logic [WORD_W-1:0] val_q;
	status_t           st_q;

	logic              rsp_vld_q;
	logic [WORD_W-1:0] rsp_val_q;
	status_t           rsp_st_q;
	logic [OCC_W-1:0]  rsp_occ_q;

	logic      accept;
	req_kind_t kind;
	logic      is_empty;
	logic      is_full;
	logic      match;
	logic      scan_last;
	logic      rsp_load;

	// Physical slot of a logical offset from the head; a single wrap is correct while the sum stays below 2*DEPTH.
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
		input logic [AW-1:0] off);
		logic [AW:0] s;
		s = {1'b0, head} + {1'b0, off};
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign accept    = req.valid && req.ready;
	assign kind      = req_kind_t'(req.req_type);
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == CW'(DEPTH));
	// The compare unit: one stored word against the search key per cycle.
	assign match     = (rd_data_q == key_q);
	assign scan_last = ((CW'(idx_q) + CW'(1)) == count_q);
	// In S_RESPOND, load the response register when it is empty or being emptied this cycle.
	assign rsp_load  = (state_q == S_RESPOND) && (!rsp_vld_q || rsp.ready);

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = rsp_vld_q;
	assign rsp.out_value = rsp_val_q;
	assign rsp.status    = rsp_st_q;
	assign rsp.occupancy = rsp_occ_q;

	// Address and write steering for each sequencer step.
	always_comb begin
		rd_addr = head_q;
		wr_en   = 1'b0;
		wr_addr = slot_of(head_q, count_q[AW-1:0]);
		wr_data = req.value;
		unique case (state_q)
			S_IDLE: begin
				// Append at the tail when there is room.
				wr_en = accept && (kind == REQ_PUSH) && !is_full;
			end
			S_SCAN: begin
				// On a match, fetch the entry just ahead; otherwise fetch the next one.
				if (match) begin
					rd_addr = slot_of(head_q, AW'(idx_q - AW'(1)));
				end else begin
					rd_addr = slot_of(head_q, AW'(idx_q + AW'(1)));
				end
			end
			S_SHIFT: begin
				// Move one entry back by one slot, prefetch the one ahead of it.
				wr_en   = 1'b1;
				wr_addr = slot_of(head_q, idx_q);
				wr_data = rd_data_q;
				rd_addr = slot_of(head_q, AW'(idx_q - AW'(2)));
			end
			S_PLACE: begin
				// The matched word equals the key, so write the key at the head.
				wr_en   = 1'b1;
				wr_addr = head_q;
				wr_data = key_q;
			end
			S_FETCH, S_RESPOND: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			key_q     <= '0;
			val_q     <= '0;
			rsp_vld_q <= 1'b0;
			rsp_val_q <= '0;
			st_q      <= ST_OK;
			rsp_st_q  <= ST_OK;
			rsp_occ_q <= '0;
		end else begin
			// Drop the response once the sink takes it, unless the next one loads now.
			if (rsp_vld_q && rsp.ready && !rsp_load) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q <= req.value;
						val_q <= '0;
						idx_q <= '0;
						st_q  <= ST_OK;
						unique case (kind)
							REQ_PUSH: begin
								if (is_full) begin
									st_q <= ST_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
								state_q <= S_RESPOND;
							end
							REQ_POP, REQ_PEEK: begin
								if (is_empty) begin
									st_q    <= ST_EMPTY;
									state_q <= S_RESPOND;
								end else begin
									if (kind == REQ_POP) begin
										count_q <= count_q - CW'(1);
										// Reset the head when the queue empties.
										if (count_q == CW'(1)) begin
											head_q <= '0;
										end else begin
											head_q <= slot_of(head_q, AW'(1));
										end
									end
									state_q <= S_FETCH;
								end
							end
							REQ_MTF: begin
								if (is_empty) begin
									st_q    <= ST_EMPTY;
									state_q <= S_RESPOND;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_FETCH: begin
					val_q   <= rd_data_q;
					state_q <= S_RESPOND;
				end
				S_SCAN: begin
					priority if (match) begin
						// A match at the head leaves the order as it is.
						state_q <= (idx_q == '0) ? S_RESPOND : S_SHIFT;
					end else if (scan_last) begin
						st_q    <= ST_NOTFOUND;
						state_q <= S_RESPOND;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				S_SHIFT: begin
					if (idx_q == AW'(1)) begin
						state_q <= S_PLACE;
					end else begin
						idx_q <= idx_q - AW'(1);
					end
				end
				S_PLACE: begin
					state_q <= S_RESPOND;
				end
				S_RESPOND: begin
					// Load the response register as soon as it is free.
					if (rsp_load) begin
						rsp_vld_q <= 1'b1;
						rsp_val_q <= val_q;
						rsp_st_q  <= st_q;
						rsp_occ_q <= OCC_W'(count_q);
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`FWMTF_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH), "count over depth")
	`FWMTF_ASSERT_SAME(a_empty_head, clk, arst_n, count_q == '0, head_q == '0, "empty but head moved")
	`FWMTF_ASSERT_SAME(a_scan_range, clk, arst_n, state_q == S_SCAN, CW'(idx_q) < count_q, "scan overrun")
	`FWMTF_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, accept, !req.ready, "request taken while busy")

endmodule
